// File: rtl/round_robin_list_interleaver_top_defines.svh
// Assertion macros shared by the round-robin list interleaver RTL.
// Depends on nothing; included by the modules that carry assertions.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef ROUND_ROBIN_LIST_INTERLEAVER_TOP_DEFINES_SVH
`define ROUND_ROBIN_LIST_INTERLEAVER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RRLI_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("round-robin list interleaver: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RRLI_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("round-robin list interleaver: assertion failed");

`else

`define RRLI_ASSERT_IMP(name, ck, rn, ante, cons)
`define RRLI_ASSERT_NXT(name, ck, rn, ante, cons)

`endif

`endif

// File: rtl/rrli_pkg.sv
// Package for the round-robin list interleaver: command and status codes,
// internal operation types and fixed field widths. Depends on nothing.
`default_nettype none

package rrli_pkg;

    // Fixed widths of the channel fields.
    localparam int CMD_W     = 2;
    localparam int LIST_ID_W = 1;
    localparam int IN_VAL_W  = 32;
    localparam int ELEM_W    = 32;
    localparam int STATUS_W  = 2;

    // Command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Decoded operation carried from the front end to the execution unit.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_NEXT,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [LIST_ID_W-1:0]   list_id;
    } op_t;

    // Queue between front end and execution unit.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Execution unit states.
    typedef enum logic {
        ST_EXEC,
        ST_READ
    } exec_state_t;

endpackage

`default_nettype wire

// File: rtl/rrli_if.sv
// Channel interfaces of the round-robin list interleaver: command input and
// result output, each with valid/ready and payload. Depends on rrli_pkg.
`default_nettype none

interface rrli_cmd_if import rrli_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [CMD_W-1:0]            command;
    logic [LIST_ID_W-1:0]        list_id;
    logic signed [IN_VAL_W-1:0]  value;

    modport source (output valid, command, list_id, value, input ready);
    modport sink   (input valid, command, list_id, value, output ready);
endinterface

interface rrli_rsp_if import rrli_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [ELEM_W-1:0]    element;
    logic [STATUS_W-1:0]         status;
    logic                        more_left;

    modport source (output valid, element, status, more_left, input ready);
    modport sink   (input valid, element, status, more_left, output ready);
endinterface

`default_nettype wire

// File: rtl/rrli_front.sv
// Front end of the interleaver: takes command transfers, decodes them into
// operations and hands them to the queue. Depends on rrli_pkg and rrli_if.
`default_nettype none

module rrli_front import rrli_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    rrli_cmd_if.sink                    cmd,
    output      logic                   push_valid,
    input  wire logic                   push_ready,
    output      op_t                    push_op,
    output      logic [VALUE_WIDTH-1:0] push_value
);

    logic                   stage_valid_reg;
    logic                   stage_valid_next;
    op_t                    stage_op_reg;
    op_t                    stage_op_next;
    logic [VALUE_WIDTH-1:0] stage_value_reg;
    logic [VALUE_WIDTH-1:0] value_fit;
    logic                   accept;

    // The stage frees up whenever its content moves into the queue.
    assign cmd.ready = !stage_valid_reg || push_ready;
    assign accept    = cmd.valid && cmd.ready;

    // Stored values keep their low VALUE_WIDTH bits; wider stores zero-extend.
    generate
        if (VALUE_WIDTH <= IN_VAL_W)
        begin : g_trunc
            assign value_fit = cmd.value[VALUE_WIDTH-1:0];
        end
        else
        begin : g_ext
            assign value_fit = {{(VALUE_WIDTH - IN_VAL_W){1'b0}}, cmd.value};
        end
    endgenerate

    // Command decode; the unused code becomes a no-op.
    always_comb
    begin
        stage_op_next.list_id = cmd.list_id;
        case (cmd.command)
            CMD_CLEAR:  stage_op_next.kind = OP_CLEAR;
            CMD_APPEND: stage_op_next.kind = OP_APPEND;
            CMD_NEXT:   stage_op_next.kind = OP_NEXT;
            default:    stage_op_next.kind = OP_NOP;
        endcase
    end

    // Stage occupancy.
    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Payload of the stage, loaded on every accepted transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_op_reg    <= stage_op_next;
            stage_value_reg <= value_fit;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_op    = stage_op_reg;
    assign push_value = stage_value_reg;

endmodule

`default_nettype wire

// File: rtl/rrli_queue.sv
// Two-entry queue that decouples the front end from the execution unit.
// Depends on rrli_pkg and the assertion macro header.
`default_nettype none
`include "round_robin_list_interleaver_top_defines.svh"

module rrli_queue import rrli_pkg::*;
#(
    parameter int DATA_W = 34
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output      logic              push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output      logic              pop_valid,
    input  wire logic              pop_ready,
    output      logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and count update; pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The count never runs past the depth, and a lone push grows it by one.
    `RRLI_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `RRLI_ASSERT_NXT(a_q_grow, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

// File: rtl/rrli_back.sv
// Execution unit of the interleaver: per-list fill and read counters, the
// element memory, the round-robin pointer and the result register.
// Depends on rrli_pkg, rrli_if and the assertion macro header.
`default_nettype none
`include "round_robin_list_interleaver_top_defines.svh"

module rrli_back import rrli_pkg::*;
#(
    parameter int NUM_LISTS   = 2,
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    output      logic                   q_pop,
    input  wire op_t                    q_op,
    input  wire logic [VALUE_WIDTH-1:0] q_value,
    rrli_rsp_if.source                  rsp
);

    localparam int LIST_W    = $clog2(NUM_LISTS);
    localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    exec_state_t            state_reg;
    exec_state_t            state_next;

    logic [CNT_W-1:0]       fill_reg [NUM_LISTS];
    logic [CNT_W-1:0]       fill_next [NUM_LISTS];
    logic [CNT_W-1:0]       rd_reg [NUM_LISTS];
    logic [CNT_W-1:0]       rd_next [NUM_LISTS];
    logic [LIST_W-1:0]      cur_reg;
    logic [LIST_W-1:0]      cur_next;

    logic [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [ELEM_W-1:0]      elem_ext;

    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic [ELEM_W-1:0]      element_reg;
    logic [ELEM_W-1:0]      element_next;
    status_t                status_reg;
    status_t                status_next;
    logic                   more_reg;
    logic                   more_next;
    logic                   pend_more_reg;

    logic                   out_free;
    logic                   read_done;
    logic                   load_out;
    logic [NUM_LISTS-1:0]   has_left;
    logic [LIST_W:0]        scan_sum;
    logic                   found;
    logic [LIST_W-1:0]      sel;
    logic [LIST_W-1:0]      lid_ext;
    logic [CNT_W-1:0]       app_cnt;
    logic                   app_full;
    logic [CNT_W-1:0]       sel_pos;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      waddr;
    logic [ADDR_W-1:0]      raddr;
    logic                   any_left_next;
    logic                   order_ok;

    // The result register can take a new result this cycle.
    assign out_free = !rsp_valid_reg || rsp.ready;

    // Next state: a next command that finds an element moves to the read state
    // while the registered memory read completes.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EXEC:
            begin
                if (q_valid && out_free && (q_op.kind == OP_NEXT) && found)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            default:
            begin
                state_next = ST_EXEC;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        q_pop     = 1'b0;
        read_done = 1'b0;
        case (state_reg)
            ST_EXEC:
            begin
                q_pop = q_valid && out_free;
            end
            ST_READ:
            begin
                read_done = 1'b1;
            end
            default:
            begin
                q_pop     = 1'b0;
                read_done = 1'b0;
            end
        endcase
    end

    // Per-list flag: unread elements remain.
    always_comb
    begin
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            has_left[i] = (rd_reg[i] < fill_reg[i]);
        end
    end

    // Cyclic scan from the current list for the first list with data left.
    always_comb
    begin
        found    = 1'b0;
        sel      = '0;
        scan_sum = '0;
        for (int k = 0; k < NUM_LISTS; k++)
        begin
            scan_sum = {1'b0, cur_reg} + (LIST_W + 1)'(k);
            if (scan_sum >= (LIST_W + 1)'(NUM_LISTS))
            begin
                scan_sum = scan_sum - (LIST_W + 1)'(NUM_LISTS);
            end
            if (!found && has_left[scan_sum[LIST_W-1:0]])
            begin
                found = 1'b1;
                sel   = scan_sum[LIST_W-1:0];
            end
        end
    end

    // Memory addresses for append and next. A 1-bit list id is always in range.
    assign lid_ext  = LIST_W'(q_op.list_id);
    assign app_cnt  = fill_reg[lid_ext];
    assign app_full = (app_cnt == CNT_W'(LIST_DEPTH));
    assign sel_pos  = rd_reg[sel];
    assign waddr    = ADDR_W'(lid_ext) * ADDR_W'(LIST_DEPTH) + ADDR_W'(app_cnt);
    assign raddr    = ADDR_W'(sel) * ADDR_W'(LIST_DEPTH) + ADDR_W'(sel_pos);
    assign mem_we   = q_pop && (q_op.kind == OP_APPEND) && !app_full;
    assign mem_re   = q_pop && (q_op.kind == OP_NEXT) && found;
    assign load_out = q_pop && !mem_re;

    // Counter and pointer updates for the operation being executed.
    always_comb
    begin
        cur_next = cur_reg;
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            fill_next[i] = fill_reg[i];
            rd_next[i]   = rd_reg[i];
            if (q_pop)
            begin
                case (q_op.kind)
                    OP_CLEAR:
                    begin
                        fill_next[i] = '0;
                        rd_next[i]   = '0;
                    end
                    OP_APPEND:
                    begin
                        if ((lid_ext == LIST_W'(i)) && !app_full)
                        begin
                            fill_next[i] = fill_reg[i] + 1'b1;
                        end
                    end
                    OP_NEXT:
                    begin
                        if (found && (sel == LIST_W'(i)))
                        begin
                            rd_next[i] = rd_reg[i] + 1'b1;
                        end
                    end
                    default:
                    begin
                        fill_next[i] = fill_reg[i];
                    end
                endcase
            end
        end
        if (q_pop && (q_op.kind == OP_CLEAR))
        begin
            cur_next = '0;
        end
        else if (mem_re)
        begin
            cur_next = (sel == LIST_W'(NUM_LISTS - 1)) ? '0 : sel + 1'b1;
        end
    end

    // Whether any list holds data after this operation.
    always_comb
    begin
        any_left_next = 1'b0;
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            if (rd_next[i] < fill_next[i])
            begin
                any_left_next = 1'b1;
            end
        end
    end

    // Element field from the memory word: low bits, zero-extended.
    generate
        if (VALUE_WIDTH >= ELEM_W)
        begin : g_elem_trunc
            assign elem_ext = rd_data_reg[ELEM_W-1:0];
        end
        else
        begin : g_elem_ext
            assign elem_ext = {{(ELEM_W - VALUE_WIDTH){1'b0}}, rd_data_reg};
        end
    endgenerate

    // Next contents of the result register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        element_next   = element_reg;
        status_next    = status_reg;
        more_next      = more_reg;
        if (read_done)
        begin
            rsp_valid_next = 1'b1;
            element_next   = elem_ext;
            status_next    = STAT_OK;
            more_next      = pend_more_reg;
        end
        else if (load_out)
        begin
            rsp_valid_next = 1'b1;
            element_next   = '0;
            more_next      = any_left_next;
            if ((q_op.kind == OP_APPEND) && app_full)
            begin
                status_next = STAT_FULL;
            end
            else if (q_op.kind == OP_NEXT)
            begin
                status_next = STAT_EMPTY;
            end
            else
            begin
                status_next = STAT_OK;
            end
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EXEC;
            cur_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                fill_reg[i] <= '0;
                rd_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            rsp_valid_reg <= rsp_valid_next;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                fill_reg[i] <= fill_next[i];
                rd_reg[i]   <= rd_next[i];
            end
        end
    end

    // Result payload and the more-left flag held while a read is in flight.
    always_ff @(posedge clk)
    begin
        element_reg <= element_next;
        status_reg  <= status_next;
        more_reg    <= more_next;
        if (mem_re)
        begin
            pend_more_reg <= any_left_next;
        end
    end

    // Element memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= q_value;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.element   = element_reg;
    assign rsp.status    = status_reg;
    assign rsp.more_left = more_reg;

    // No list is read past its fill level.
    always_comb
    begin
        order_ok = 1'b1;
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            if (rd_reg[i] > fill_reg[i])
            begin
                order_ok = 1'b0;
            end
        end
    end

    `RRLI_ASSERT_IMP(a_read_slot_free, clk, rst_n, state_reg == ST_READ, !rsp_valid_reg)
    `RRLI_ASSERT_IMP(a_pos_bound, clk, rst_n, 1'b1, order_ok)
    `RRLI_ASSERT_NXT(a_empty_no_more, clk, rst_n, q_pop && (q_op.kind == OP_NEXT) && !found, rsp_valid_reg && !more_reg)

endmodule

`default_nettype wire

// File: rtl/round_robin_list_interleaver_top.sv
// Round-robin list interleaver, top level: front end, queue and execution unit.
// A clear, append or unused command is executed in the execute state alone and
// a next command that finds an element also passes through the read state, for
// the registered read port of the element memory; commands pass through the
// front stage and the two-entry queue on their way to execution, and results
// leave through a result register; execution stalls while a result waits there.
// The element memory holds NUM_LISTS * LIST_DEPTH words and needs no clearing
// pass after reset: only entries below a list's fill level are ever read.
// Depends on rrli_pkg, rrli_if, rrli_front, rrli_queue and rrli_back.
`default_nettype none

module round_robin_list_interleaver_top import rrli_pkg::*;
#(
    parameter int NUM_LISTS   = 2,
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rrli_cmd_if.sink    cmd,
    rrli_rsp_if.source  rsp
);

    localparam int Q_DATA_W = $bits(op_t) + VALUE_WIDTH;

    logic                   f_valid;
    logic                   f_ready;
    op_t                    f_op;
    logic [VALUE_WIDTH-1:0] f_value;
    logic [Q_DATA_W-1:0]    q_in;
    logic [Q_DATA_W-1:0]    q_out;
    logic                   q_valid;
    logic                   q_pop;
    op_t                    q_op;
    logic [VALUE_WIDTH-1:0] q_value;

    // Command transfers are decoded and staged here.
    rrli_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_op    (f_op),
        .push_value (f_value)
    );

    assign q_in = {f_op, f_value};

    // Short queue between decode and execution.
    rrli_queue #(
        .DATA_W (Q_DATA_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_out)
    );

    assign {q_op, q_value} = q_out;

    // Lists, element memory and result register.
    rrli_back #(
        .NUM_LISTS   (NUM_LISTS),
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_op    (q_op),
        .q_value (q_value),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

// File: tb/round_robin_list_interleaver_top_test.sv
// Testbench for the round-robin list interleaver top level: directed and random command
// streams, checked against an in-bench model of the lists and the round-robin pointer.
// Depends on rrli_pkg, rrli_if and round_robin_list_interleaver_top.
`timescale 1ns / 1ps

module round_robin_list_interleaver_top_test;
    import rrli_pkg::*;

    localparam int N_LISTS    = 2;
    localparam int DEPTH      = 64;
    localparam int RAND_ITEMS = 450;

    // The command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]           command;
        logic [LIST_ID_W-1:0]       list_id;
        logic signed [IN_VAL_W-1:0] value;
        bit                         drain;
    } cmd_item_t;

    typedef struct {
        logic signed [ELEM_W-1:0] element;
        status_t                  status;
        logic                     more_left;
    } result_t;

    logic clk;
    logic rst_n;

    rrli_cmd_if cmd_ch ();
    rrli_rsp_if rsp_ch ();

    round_robin_list_interleaver_top #(
        .NUM_LISTS   (N_LISTS),
        .LIST_DEPTH  (DEPTH),
        .VALUE_WIDTH (IN_VAL_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Commands waiting to be driven and results waiting to arrive.
    cmd_item_t cmd_backlog[$];
    result_t   pending_results[$];

    // Copy of the list contents, fill levels, read positions and pointer.
    logic [ELEM_W-1:0] list_mem [N_LISTS][DEPTH];
    int                fill_lvl [N_LISTS];
    int                rd_pos   [N_LISTS];
    int                cur_list;

    int  error_count;
    int  items_total;
    int  items_accepted;
    bit  cmd_fire;
    int  burst_left;
    int  gap_left;
    int  stall_mode;
    int  stall_left;
    int  stall_phase;
    int  random_count;
    int  seq_idx;

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one command to the list state and returns the result it produces.
    function automatic result_t predict_interleave(cmd_item_t it);
        result_t r;
        int      l;
        int      k;
        bit      served;
        r.element   = '0;
        r.status    = STAT_OK;
        r.more_left = 1'b0;
        served      = 1'b0;
        case (it.command)
            CMD_CLEAR:
            begin
                foreach (fill_lvl[i])
                begin
                    fill_lvl[i] = 0;
                    rd_pos[i]   = 0;
                end
                cur_list = 0;
            end
            CMD_APPEND:
            begin
                if (it.list_id < N_LISTS)
                begin
                    if (fill_lvl[it.list_id] >= DEPTH)
                        r.status = STAT_FULL;
                    else
                    begin
                        list_mem[it.list_id][fill_lvl[it.list_id]] = it.value;
                        fill_lvl[it.list_id]++;
                    end
                end
            end
            CMD_NEXT:
            begin
                // Cyclic scan starting at the current list.
                for (k = 0; k < N_LISTS && !served; k++)
                begin
                    l = (cur_list + k) % N_LISTS;
                    if (rd_pos[l] < fill_lvl[l])
                    begin
                        r.element = list_mem[l][rd_pos[l]];
                        rd_pos[l]++;
                        cur_list = (l + 1) % N_LISTS;
                        served   = 1'b1;
                    end
                end
                if (!served)
                    r.status = STAT_EMPTY;
            end
            default: ;
        endcase
        foreach (fill_lvl[i])
        begin
            if (rd_pos[i] < fill_lvl[i])
                r.more_left = 1'b1;
        end
        return r;
    endfunction

    function automatic void add_item(logic [CMD_W-1:0] command, logic [LIST_ID_W-1:0] list_id,
                                     logic signed [IN_VAL_W-1:0] value, bit drain);
        cmd_item_t it;
        it.command = command;
        it.list_id = list_id;
        it.value   = value;
        it.drain   = drain;
        cmd_backlog = {cmd_backlog, it};
    endfunction

    // Random element value, weighted toward the extremes.
    function automatic logic signed [IN_VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Adds one random command to the backlog; ignored commands do not count.
    function automatic void add_random(logic [CMD_W-1:0] command, logic [LIST_ID_W-1:0] list_id,
                                       bit drain);
        logic [CMD_W-1:0] c;
        c = command;
        if ($urandom_range(0, 11) == 0)
            c = CMD_W'($urandom_range(0, 3));
        add_item(c, list_id, pick_value(), drain);
        if (c != CMD_UNUSED)
            random_count++;
    endfunction

    // Command side: prediction on each transfer.
    always @(posedge clk)
    begin
        cmd_fire = rst_n && cmd_ch.valid && cmd_ch.ready;
        if (cmd_fire)
        begin
            cmd_item_t it;
            it.command = cmd_ch.command;
            it.list_id = cmd_ch.list_id;
            it.value   = cmd_ch.value;
            it.drain   = 1'b0;
            pending_results = {pending_results, predict_interleave(it)};
            items_accepted++;
        end
    end

    // Result side: each transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: element %0h status %0d more_left %0b",
                       rsp_ch.element, rsp_ch.status, rsp_ch.more_left);
                error_count++;
            end
            else
            begin
                result_t exp_r;
                exp_r = pending_results.pop_front();
                if (rsp_ch.element !== exp_r.element)
                begin
                    $error("element: expected %0h, actual %0h", exp_r.element, rsp_ch.element);
                    error_count++;
                end
                if (rsp_ch.status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.more_left !== exp_r.more_left)
                begin
                    $error("more_left: expected %0b, actual %0b",
                           exp_r.more_left, rsp_ch.more_left);
                    error_count++;
                end
            end
        end
    end

    // Command driver: bursts of transfers separated by random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (!cmd_ch.valid || cmd_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_backlog.size() == 0 ||
                     (cmd_backlog[0].drain && pending_results.size() != 0))
                cmd_ch.valid <= 1'b0;
            else
            begin
                cmd_item_t it;
                it = cmd_backlog.pop_front();
                cmd_ch.valid   <= 1'b1;
                cmd_ch.command <= it.command;
                cmd_ch.list_id <= it.list_id;
                cmd_ch.value   <= it.value;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
        end
    end

    // Result receiver: stall pattern in one of four modes, redrawn when its hold counter runs out.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            stall_phase++;
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 80);
            end
            else
                stall_left--;
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                2: rsp_ch.ready <= (stall_phase % 3 == 0);
                default: rsp_ch.ready <= (stall_phase % 8 < 5);
            endcase
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int n;
        int m;
        int tgt;
        bit fill_seq;
        bit drain;
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_CLEAR;
        cmd_ch.list_id = '0;
        cmd_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        error_count    = 0;
        items_accepted = 0;
        cmd_fire       = 1'b0;
        burst_left     = 0;
        gap_left       = 0;
        stall_mode     = 0;
        stall_left     = 0;
        stall_phase    = 0;
        random_count   = 0;
        cur_list       = 0;
        foreach (fill_lvl[i])
        begin
            fill_lvl[i] = 0;
            rd_pos[i]   = 0;
        end

        // Next and the ignored code on empty lists.
        add_item(CMD_NEXT, 1'b0, '0, 1'b0);
        add_item(CMD_UNUSED, 1'b1, -32'sd1, 1'b0);
        // Extreme values into both lists, then an interleaved read-out.
        add_item(CMD_APPEND, 1'b0, 32'sh7FFF_FFFF, 1'b0);
        add_item(CMD_APPEND, 1'b1, 32'sh8000_0000, 1'b0);
        add_item(CMD_APPEND, 1'b0, 32'sh0000_0000, 1'b0);
        add_item(CMD_APPEND, 1'b1, -32'sd1, 1'b0);
        add_item(CMD_APPEND, 1'b0, 32'sh5555_5555, 1'b0);
        add_item(CMD_UNUSED, 1'b0, 32'sh1234_5678, 1'b0);
        add_item(CMD_NEXT, 1'b0, '0, 1'b0);
        add_item(CMD_NEXT, 1'b1, '0, 1'b0);
        add_item(CMD_NEXT, 1'b0, '0, 1'b0);
        add_item(CMD_NEXT, 1'b0, '0, 1'b0);
        // List 1 is drained, so one more element comes from list 0, then both lists are empty.
        add_item(CMD_NEXT, 1'b0, '0, 1'b0);
        add_item(CMD_NEXT, 1'b0, '0, 1'b0);
        // Only list 1 filled while the pointer sits on list 1.
        add_item(CMD_APPEND, 1'b1, 32'shAAAA_AAAA, 1'b0);
        add_item(CMD_NEXT, 1'b0, '0, 1'b0);
        // Clear with elements left and the pointer on list 1.
        add_item(CMD_APPEND, 1'b0, 32'sh0F0F_0F0F, 1'b0);
        add_item(CMD_APPEND, 1'b1, 32'shF0F0_F0F0, 1'b0);
        add_item(CMD_NEXT, 1'b0, '0, 1'b0);
        add_item(CMD_CLEAR, 1'b1, -32'sd1, 1'b0);
        add_item(CMD_APPEND, 1'b1, 32'sh0000_0001, 1'b0);
        add_item(CMD_APPEND, 1'b0, 32'sh0000_0002, 1'b0);
        add_item(CMD_NEXT, 1'b0, '0, 1'b0);
        add_item(CMD_CLEAR, 1'b0, '0, 1'b0);
        add_item(CMD_NEXT, 1'b1, '0, 1'b0);

        // Random sequences: an optional clear, a run of appends, then reads
        // until the lists run dry. Some sequences overfill one list.
        seq_idx = 0;
        while (random_count < RAND_ITEMS)
        begin
            fill_seq = (seq_idx == 0) || ($urandom_range(0, 9) == 0);
            drain    = (seq_idx == 1) || ($urandom_range(0, 4) == 0);
            if (fill_seq)
            begin
                tgt = $urandom_range(0, 1);
                add_random(CMD_CLEAR, '0, drain);
                n = DEPTH + $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_item(CMD_APPEND, tgt[0], pick_value(), 1'b0);
                random_count += n;
                m = $urandom_range(0, 4);
                for (int i = 0; i < m; i++)
                    add_random(CMD_APPEND, ~tgt[0], 1'b0);
                n = DEPTH + m + $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_random(CMD_NEXT, LIST_ID_W'($urandom_range(0, 1)), 1'b0);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    add_random(CMD_CLEAR, LIST_ID_W'($urandom_range(0, 1)), drain);
                else
                    add_random(CMD_APPEND, LIST_ID_W'($urandom_range(0, 1)), drain);
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    add_random(CMD_APPEND, LIST_ID_W'($urandom_range(0, 1)), 1'b0);
                m = n + $urandom_range(0, 3);
                for (int i = 0; i < m; i++)
                    add_random(CMD_NEXT, LIST_ID_W'($urandom_range(0, 1)), 1'b0);
            end
            seq_idx++;
        end
        items_total = cmd_backlog.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every command transfer, then for every result.
        while (items_accepted < items_total)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("round_robin_list_interleaver_top_test: clean");
        else
            $display("round_robin_list_interleaver_top_test: errors");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #3ms;
        $display("round_robin_list_interleaver_top_test: errors");
        $finish;
    end

endmodule
